### rtl/core/cursor_array_list_macros.svh
// Assertion macros shared by the cursor_array_list RTL.
// Needs nothing else; included by the modules that carry assertions.
`ifndef CURSOR_ARRAY_LIST_MACROS_SVH
`define CURSOR_ARRAY_LIST_MACROS_SVH

`ifndef SYNTHESIS
`define CAL_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define CAL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define CAL_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define CAL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/cal_pkg.sv
// Shared types and constants of the cursor_array_list block.
// No dependencies; used by every module of the block except cal_ram.
package cal_pkg;

    localparam int CAPACITY = 32;
    localparam int ENTRY_W  = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;
    localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_FIELDS_W = ENTRY_W + 1 + CNT_W + STAT_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_START   = 3'd0,
        CMD_ADVANCE = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_ATTACH  = 3'd3,
        CMD_REMOVE  = 3'd4,
        CMD_READ    = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NO_ITEM = 2'd2
    } stat_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_DRAIN,
        S_WRITE,
        S_LOOKUP,
        S_DATA
    } cal_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic plan;
        logic shift_step;
        logic write_word;
        logic lookup;
        logic load_out;
    } cal_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic plan_shift;
        logic plan_write;
        logic write_due;
        logic last_step;
        logic out_free;
    } cal_stat_t;

endpackage

### rtl/core/cal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cal_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [DATA_W-1:0]          wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [DATA_W-1:0]          rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/cal_ctrl.sv
// Sequencer of the cursor_array_list: one command at a time through
// plan, entry shift, store write, lookup and result load. Uses cal_pkg.
module cal_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cal_pkg::cal_stat_t  stat,
    output cal_pkg::cal_cmd_t   cmd
);

    cal_pkg::cal_state_t state_reg;
    cal_pkg::cal_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cal_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            cal_pkg::S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = cal_pkg::S_DECIDE;
                end
            end
            cal_pkg::S_DECIDE:
            begin
                cmd.plan = 1'b1;
                if (stat.plan_shift)
                begin
                    state_next = cal_pkg::S_SHIFT;
                end
                else if (stat.plan_write)
                begin
                    state_next = cal_pkg::S_WRITE;
                end
                else
                begin
                    state_next = cal_pkg::S_LOOKUP;
                end
            end
            cal_pkg::S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (stat.last_step)
                begin
                    state_next = cal_pkg::S_DRAIN;
                end
            end
            cal_pkg::S_DRAIN:
            begin
                // last moved entry is written back this cycle
                state_next = stat.write_due ? cal_pkg::S_WRITE : cal_pkg::S_LOOKUP;
            end
            cal_pkg::S_WRITE:
            begin
                cmd.write_word = 1'b1;
                state_next     = cal_pkg::S_LOOKUP;
            end
            cal_pkg::S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = cal_pkg::S_DATA;
            end
            cal_pkg::S_DATA:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = cal_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cal_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/cal_dp.sv
// Datapath of the cursor_array_list: count and cursor, command planning,
// entry store (cal_ram) with shift pipeline, output register. Uses cal_pkg.
`include "cursor_array_list_macros.svh"

module cal_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cal_pkg::cal_cmd_t                cmd,
    output cal_pkg::cal_stat_t               stat,
    input  logic [cal_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [cal_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cal_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int IDX_W = cal_pkg::IDX_W;
    localparam int CNT_W = cal_pkg::CNT_W;
    localparam int EW    = cal_pkg::ENTRY_W;

    // item payload
    cal_pkg::cmd_t           op_reg;
    logic [EW-1:0]           word_reg;

    // list state
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        cursor_reg, cursor_next;
    cal_pkg::stat_code_t     status_reg, status_next;

    // shift sequencing
    logic                    up_reg, up_next;
    logic [IDX_W-1:0]        addr_reg, addr_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic                    write_due_reg, write_due_next;
    logic                    wr_pend_reg;
    logic [IDX_W-1:0]        wr_addr_reg;

    // output register
    logic                    out_valid_reg;
    logic [cal_pkg::M_FIELDS_W-1:0] out_data_reg;

    // plan signals
    logic                    cur_valid;
    logic                    full;
    logic [CNT_W-1:0]        ins_pos;
    logic [CNT_W-1:0]        p_rem;
    logic                    p_write;
    logic                    has_item;

    // RAM
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [EW-1:0]           ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [EW-1:0]           ram_rdata;

    assign cur_valid = cursor_reg < count_reg;
    assign full      = count_reg >= CNT_W'(cal_pkg::CAPACITY);
    assign has_item  = cursor_reg < count_reg;

    always_comb
    begin
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        status_next    = cal_pkg::ST_OK;
        up_next        = 1'b1;
        addr_next      = IDX_W'(count_reg - CNT_W'(1));
        ins_pos        = count_reg;
        p_rem          = '0;
        p_write        = 1'b0;
        case (op_reg)
            cal_pkg::CMD_START:
            begin
                cursor_next = '0;
            end
            cal_pkg::CMD_ADVANCE:
            begin
                if (cur_valid)
                begin
                    cursor_next = cursor_reg + CNT_W'(1);
                end
                else
                begin
                    status_next = cal_pkg::ST_NO_ITEM;
                end
            end
            cal_pkg::CMD_INSERT, cal_pkg::CMD_ATTACH:
            begin
                if (full)
                begin
                    status_next = cal_pkg::ST_FULL;
                end
                else
                begin
                    if (op_reg == cal_pkg::CMD_INSERT)
                    begin
                        ins_pos = cur_valid ? cursor_reg : '0;
                    end
                    else
                    begin
                        ins_pos = cur_valid ? (cursor_reg + CNT_W'(1)) : count_reg;
                    end
                    // entries pos..count-1 move up by one, top first
                    p_rem       = count_reg - ins_pos;
                    p_write     = 1'b1;
                    cursor_next = ins_pos;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            cal_pkg::CMD_REMOVE:
            begin
                if (cur_valid)
                begin
                    // entries cursor+1..count-1 move down by one, bottom first
                    up_next    = 1'b0;
                    addr_next  = IDX_W'(cursor_reg + CNT_W'(1));
                    p_rem      = count_reg - cursor_reg - CNT_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = cal_pkg::ST_NO_ITEM;
                end
            end
            cal_pkg::CMD_READ:
            begin
                if (!cur_valid)
                begin
                    status_next = cal_pkg::ST_NO_ITEM;
                end
            end
            default:
            begin
                status_next = cal_pkg::ST_OK;
            end
        endcase
        pos_next       = IDX_W'(ins_pos);
        write_due_next = p_write;
        rem_next       = p_rem;
    end

    assign stat.plan_shift = p_rem != '0;
    assign stat.plan_write = p_write;
    assign stat.write_due  = write_due_reg;
    assign stat.last_step  = rem_reg == CNT_W'(1);
    assign stat.out_free   = !out_valid_reg || m_tready;

    // store access
    always_comb
    begin
        ram_re    = cmd.shift_step || cmd.lookup;
        ram_raddr = cmd.lookup ? cursor_reg[IDX_W-1:0] : addr_reg;
        ram_we    = wr_pend_reg || cmd.write_word;
        ram_waddr = cmd.write_word ? pos_reg : wr_addr_reg;
        ram_wdata = cmd.write_word ? word_reg : ram_rdata;
    end

    cal_ram #(
        .DATA_W (EW),
        .DEPTH  (cal_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            write_due_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= cmd.shift_step;
            if (cmd.plan)
            begin
                count_reg     <= count_next;
                cursor_reg    <= cursor_next;
                write_due_reg <= write_due_next;
                rem_reg       <= rem_next;
            end
            else if (cmd.shift_step)
            begin
                rem_reg <= rem_reg - CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= cal_pkg::cmd_t'(s_tuser[cal_pkg::CMD_W-1:0]);
            word_reg <= s_tdata[EW-1:0];
        end
        if (cmd.plan)
        begin
            status_reg <= status_next;
            up_reg     <= up_next;
            addr_reg   <= addr_next;
            pos_reg    <= pos_next;
        end
        else if (cmd.shift_step)
        begin
            addr_reg <= up_reg ? (addr_reg - IDX_W'(1)) : (addr_reg + IDX_W'(1));
        end
        if (cmd.shift_step)
        begin
            wr_addr_reg <= up_reg ? (addr_reg + IDX_W'(1)) : (addr_reg - IDX_W'(1));
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {status_reg, count_reg, has_item,
                             has_item ? ram_rdata : {EW{1'b0}}};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cal_pkg::M_TDATA_W'(out_data_reg);

    `CAL_ASSERT_ALWAYS(a_cursor_in_range, clk, rst_n, cursor_reg <= count_reg)
    `CAL_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= CNT_W'(cal_pkg::CAPACITY))
    `CAL_ASSERT_IMPL(a_no_rw_collision, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr)
    `CAL_ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.load_out, !out_valid_reg || m_tready)

endmodule

### rtl/core/cursor_array_list.sv
// cursor_array_list: bounded list of 32-bit entries with a cursor.
// Each command passes plan, lookup and result load; insert, attach and remove also
// move entries by one place (one RAM read/write per moved entry), and insert/attach
// add a store write. One item at a time: the next item is taken the cycle after
// the result is loaded, and the load waits while m_tvalid is held without m_tready.
// Reset (rst_n low, async) empties the list and puts the cursor at 0; store not cleared.
module cursor_array_list (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cal_pkg::S_TDATA_W-1:0]   s_tdata,  // entry_value[31:0]
    input  logic [cal_pkg::S_TUSER_W-1:0]   s_tuser,  // command[2:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // current_value[31:0], has_item[32], item_count[38:33], status[40:39], zero pad
    output logic [cal_pkg::M_TDATA_W-1:0]   m_tdata
);

    cal_pkg::cal_cmd_t  cmd;
    cal_pkg::cal_stat_t stat;

    cal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cal_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
